// ===== src/blae_pkg.sv =====
// ----------------------------------------------------------------------------
// blae_pkg: shared types and microcode for the bounded array list engine
// Holds the item structs, the control word layout, the step labels, the
// microcode table and the dispatch table that maps an operation to its
// first step.
// ----------------------------------------------------------------------------
package blae_pkg;

  localparam int CAPACITY = 8;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 4;
  localparam int UPC_W    = 5;

  // Operation codes carried in the kind field.
  localparam logic [KIND_W-1:0] KIND_APPEND       = 4'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT       = 4'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_REMOVE_FIRST = 4'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVE_ALL   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_WRITE_AT     = 4'd5;
  localparam logic [KIND_W-1:0] KIND_WRITE_MATCH  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_READ_AT      = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FIND         = 4'd8;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [ADDR_W-1:0]        index;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } blae_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [ADDR_W-1:0]        position;
    logic [CNT_W-1:0]         count;
  } blae_out_t;

  typedef logic [UPC_W-1:0] upc_t;

  // Branch conditions. C_NEXT never branches.
  typedef enum logic [3:0] {
    C_NEXT, C_ALWAYS, C_FULL, C_INS_BAD, C_IDX_BAD, C_I_LE_IDX,
    C_SHIFT_DONE, C_SCAN_DONE, C_NOMATCH, C_IS_FIND, C_IS_WM
  } cond_t;

  typedef enum logic [1:0] {RA_I, RA_IM1, RA_IP1, RA_IDX} ra_sel_t;
  typedef enum logic [1:0] {WE_NONE, WE_ALWAYS, WE_NOMATCH} we_sel_t;
  typedef enum logic [1:0] {WA_CNT, WA_IDX, WA_I, WA_W} wa_sel_t;
  typedef enum logic [1:0] {WD_VAL, WD_NVAL, WD_RDATA} wd_sel_t;
  typedef enum logic [2:0] {
    I_HOLD, I_ZERO, I_CNT, I_IDX, I_INC, I_DEC, I_INC_NOMATCH
  } iop_t;
  typedef enum logic [1:0] {W_HOLD, W_ZERO, W_INC_NOMATCH} wop_t;
  typedef enum logic [1:0] {N_HOLD, N_INC, N_DEC, N_LOAD_W} nop_t;
  typedef enum logic [2:0] {R_NONE, R_OK, R_READ, R_POS, R_ALL} res_t;

  typedef struct packed {
    cond_t   cond;
    upc_t    target;
    logic    fin;
    ra_sel_t ra;
    we_sel_t we;
    wa_sel_t wa;
    wd_sel_t wd;
    iop_t    iop;
    wop_t    wop;
    nop_t    nop;
    res_t    res;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic ins_bad;
    logic idx_bad;
    logic i_le_idx;
    logic shift_done;
    logic scan_done;
    logic nomatch;
    logic is_find;
    logic is_wm;
  } status_t;

  // Step labels of the microprogram.
  localparam upc_t S_END   = 5'd0;
  localparam upc_t S_APP   = 5'd1;
  localparam upc_t S_APP1  = 5'd2;
  localparam upc_t S_INS0  = 5'd3;
  localparam upc_t S_INS1  = 5'd4;
  localparam upc_t S_INS2  = 5'd5;
  localparam upc_t S_INS3  = 5'd6;
  localparam upc_t S_RMA0  = 5'd7;
  localparam upc_t S_SHD   = 5'd8;
  localparam upc_t S_SHD1  = 5'd9;
  localparam upc_t S_SHE   = 5'd10;
  localparam upc_t S_SRCH  = 5'd11;
  localparam upc_t S_SR1   = 5'd12;
  localparam upc_t S_SR2   = 5'd13;
  localparam upc_t S_HIT   = 5'd14;
  localparam upc_t S_HIT1  = 5'd15;
  localparam upc_t S_HIT2  = 5'd16;
  localparam upc_t S_FND   = 5'd17;
  localparam upc_t S_WM    = 5'd18;
  localparam upc_t S_RAL   = 5'd19;
  localparam upc_t S_RAL1  = 5'd20;
  localparam upc_t S_RAL2  = 5'd21;
  localparam upc_t S_RALE  = 5'd22;
  localparam upc_t S_WRA   = 5'd23;
  localparam upc_t S_WRA1  = 5'd24;
  localparam upc_t S_RDA   = 5'd25;
  localparam upc_t S_RDA1  = 5'd26;

  localparam ctrl_t CTRL_NOP = '{cond: C_NEXT, target: S_END, fin: 1'b0, ra: RA_I,
                                 we: WE_NONE, wa: WA_CNT, wd: WD_VAL, iop: I_HOLD,
                                 wop: W_HOLD, nop: N_HOLD, res: R_NONE};

  // First step of each operation; unused codes go straight to the end step.
  function automatic upc_t entry_step(logic [KIND_W-1:0] kind);
    upc_t s;
    unique case (kind) inside
      KIND_APPEND:                                  s = S_APP;
      KIND_INSERT:                                  s = S_INS0;
      KIND_REMOVE_AT:                               s = S_RMA0;
      KIND_REMOVE_FIRST, KIND_WRITE_MATCH, KIND_FIND: s = S_SRCH;
      KIND_REMOVE_ALL:                              s = S_RAL;
      KIND_WRITE_AT:                                s = S_WRA;
      KIND_READ_AT:                                 s = S_RDA;
      default:                                      s = S_END;
    endcase
    return s;
  endfunction

  // The microprogram. A read issued in one step is seen as read data in the
  // following step.
  function automatic ctrl_t ucode_rom(upc_t a);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (a)
      S_END: begin
        c.fin = 1'b1;
      end
      S_APP: begin
        c.cond = C_FULL; c.target = S_END;
      end
      S_APP1: begin
        c.we = WE_ALWAYS; c.wa = WA_CNT; c.wd = WD_VAL;
        c.nop = N_INC; c.res = R_OK; c.fin = 1'b1;
      end
      S_INS0: begin
        c.cond = C_INS_BAD; c.target = S_END; c.iop = I_CNT;
      end
      S_INS1: begin
        c.ra = RA_IM1; c.cond = C_I_LE_IDX; c.target = S_INS3;
      end
      S_INS2: begin
        c.we = WE_ALWAYS; c.wa = WA_I; c.wd = WD_RDATA; c.iop = I_DEC;
        c.cond = C_ALWAYS; c.target = S_INS1;
      end
      S_INS3: begin
        c.we = WE_ALWAYS; c.wa = WA_IDX; c.wd = WD_VAL;
        c.nop = N_INC; c.res = R_OK; c.fin = 1'b1;
      end
      S_RMA0: begin
        c.cond = C_IDX_BAD; c.target = S_END; c.iop = I_IDX;
      end
      S_SHD: begin
        c.ra = RA_IP1; c.cond = C_SHIFT_DONE; c.target = S_SHE;
      end
      S_SHD1: begin
        c.we = WE_ALWAYS; c.wa = WA_I; c.wd = WD_RDATA; c.iop = I_INC;
        c.cond = C_ALWAYS; c.target = S_SHD;
      end
      S_SHE: begin
        c.nop = N_DEC; c.res = R_OK; c.fin = 1'b1;
      end
      S_SRCH: begin
        c.iop = I_ZERO;
      end
      S_SR1: begin
        c.ra = RA_I; c.cond = C_SCAN_DONE; c.target = S_END;
      end
      S_SR2: begin
        c.iop = I_INC_NOMATCH; c.cond = C_NOMATCH; c.target = S_SR1;
      end
      S_HIT: begin
        c.cond = C_IS_FIND; c.target = S_FND;
      end
      S_HIT1: begin
        c.cond = C_IS_WM; c.target = S_WM;
      end
      S_HIT2: begin
        c.cond = C_ALWAYS; c.target = S_SHD;
      end
      S_FND: begin
        c.res = R_POS; c.fin = 1'b1;
      end
      S_WM: begin
        c.we = WE_ALWAYS; c.wa = WA_I; c.wd = WD_NVAL;
        c.res = R_OK; c.fin = 1'b1;
      end
      S_RAL: begin
        c.iop = I_ZERO; c.wop = W_ZERO;
      end
      S_RAL1: begin
        c.ra = RA_I; c.cond = C_SCAN_DONE; c.target = S_RALE;
      end
      S_RAL2: begin
        c.we = WE_NOMATCH; c.wa = WA_W; c.wd = WD_RDATA;
        c.wop = W_INC_NOMATCH; c.iop = I_INC;
        c.cond = C_ALWAYS; c.target = S_RAL1;
      end
      S_RALE: begin
        c.res = R_ALL; c.nop = N_LOAD_W; c.fin = 1'b1;
      end
      S_WRA: begin
        c.cond = C_IDX_BAD; c.target = S_END;
      end
      S_WRA1: begin
        c.we = WE_ALWAYS; c.wa = WA_IDX; c.wd = WD_VAL;
        c.res = R_OK; c.fin = 1'b1;
      end
      S_RDA: begin
        c.ra = RA_IDX; c.cond = C_IDX_BAD; c.target = S_END;
      end
      S_RDA1: begin
        c.res = R_READ; c.fin = 1'b1;
      end
      default: begin
        c.fin = 1'b1;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== src/bounded_array_list_engine_unit.sv =====
// The sequencer runs one microcode step at a time; list walks take two steps per entry, and
// removing an entry of a full list by value is the longest case, wherever the entry sits.
// Items are handled one at a time; busy falls after the last step, so the next item can be
// taken in the strobe cycle. The receiver cannot stall; the strobe lasts one cycle.
// Reset (synchronous, active low) empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
// bounded_array_list_engine_unit: bounded ordered list engine
// A microcoded sequencer steps a small datapath through append, insert,
// removals, overwrites, reads and searches on a list held in an entry memory.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  blae_pkg::blae_in_t   in_item,
  output logic                 out_valid,
  output blae_pkg::blae_out_t  out_item
);
  import blae_pkg::*;

  // An item is taken when start is seen while the sequencer is idle. The
  // datapath latches its fields on that same edge and the sequencer jumps
  // to the first step of the selected operation.
  logic    accept;
  logic    active;
  logic    done;
  ctrl_t   ctrl;
  status_t status;

  assign accept = start & ~active;
  assign busy   = active;

  // The sequencer owns the step counter and the control store. Each cycle it
  // presents one control word, and picks the next step from the branch
  // condition that the datapath reports.
  blae_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .kind   (in_item.kind),
    .status (status),
    .ctrl   (ctrl),
    .active (active),
    .done   (done)
  );

  // The datapath holds the entries, the fill count and the walking pointers.
  // Its result registers feed the output ports directly; the strobe rises in the cycle
  // after the final step, so a new item can be accepted during the strobe cycle
  // itself.
  blae_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .step_en   (active),
    .done      (done),
    .ctrl      (ctrl),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== src/blae_seq.sv =====
// ----------------------------------------------------------------------------
// blae_seq: microcode sequencer
// Step counter, control store lookup and branch selection.
// ----------------------------------------------------------------------------
module blae_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [blae_pkg::KIND_W-1:0] kind,
  input  blae_pkg::status_t           status,
  output blae_pkg::ctrl_t             ctrl,
  output logic                        active,
  output logic                        done
);
  import blae_pkg::*;

  logic  active_r, active_nxt;
  upc_t  upc_r, upc_nxt;
  logic  take;

  assign ctrl   = ucode_rom(upc_r);
  assign active = active_r;
  assign done   = active_r & ctrl.fin;

  always_comb begin
    unique case (ctrl.cond)
      C_NEXT:       take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_FULL:       take = status.full;
      C_INS_BAD:    take = status.ins_bad;
      C_IDX_BAD:    take = status.idx_bad;
      C_I_LE_IDX:   take = status.i_le_idx;
      C_SHIFT_DONE: take = status.shift_done;
      C_SCAN_DONE:  take = status.scan_done;
      C_NOMATCH:    take = status.nomatch;
      C_IS_FIND:    take = status.is_find;
      C_IS_WM:      take = status.is_wm;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    upc_nxt    = upc_r;
    active_nxt = active_r;
    if (accept) begin
      upc_nxt    = entry_step(kind);
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (ctrl.fin) begin
        active_nxt = 1'b0;
      end else if (take) begin
        upc_nxt = ctrl.target;
      end else begin
        upc_nxt = upc_t'(upc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      upc_r    <= S_END;
    end else begin
      active_r <= active_nxt;
      upc_r    <= upc_nxt;
    end
  end

endmodule

// ===== src/blae_dpath.sv =====
// ----------------------------------------------------------------------------
// blae_dpath: list storage and datapath
// Entry memory with a registered read port, pointers, count and result
// registers, all driven by the current control word.
// ----------------------------------------------------------------------------
module blae_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  blae_pkg::blae_in_t   in_item,
  input  logic                 step_en,
  input  logic                 done,
  input  blae_pkg::ctrl_t      ctrl,
  output blae_pkg::status_t    status,
  output logic                 out_valid,
  output blae_pkg::blae_out_t  out_item
);
  import blae_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  blae_in_t          item_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [CNT_W-1:0]  w_r, w_nxt;
  logic              ok_r, ok_nxt;
  logic [DATA_W-1:0] rd_r, rd_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic              out_valid_r;

  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  i_m1;
  logic [CNT_W-1:0]  i_p1;
  logic              match;
  logic              mem_we;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;

  assign idx_ext = CNT_W'(item_r.index);
  assign i_m1    = i_r - CNT_W'(1);
  assign i_p1    = i_r + CNT_W'(1);
  assign match   = (rdata_r == item_r.value);

  always_comb begin
    status.full       = (cnt_r == CNT_W'(CAPACITY));
    status.idx_bad    = (idx_ext >= cnt_r);
    status.ins_bad    = status.full | status.idx_bad;
    status.i_le_idx   = (i_r <= idx_ext);
    status.shift_done = (i_p1 >= cnt_r);
    status.scan_done  = (i_r >= cnt_r);
    status.nomatch    = ~match;
    status.is_find    = (item_r.kind == KIND_FIND);
    status.is_wm      = (item_r.kind == KIND_WRITE_MATCH);
  end

  always_comb begin
    unique case (ctrl.ra)
      RA_I:    raddr = i_r[ADDR_W-1:0];
      RA_IM1:  raddr = i_m1[ADDR_W-1:0];
      RA_IP1:  raddr = i_p1[ADDR_W-1:0];
      RA_IDX:  raddr = item_r.index;
      default: raddr = i_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (ctrl.wa)
      WA_CNT:  waddr = cnt_r[ADDR_W-1:0];
      WA_IDX:  waddr = item_r.index;
      WA_I:    waddr = i_r[ADDR_W-1:0];
      WA_W:    waddr = w_r[ADDR_W-1:0];
      default: waddr = i_r[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    unique case (ctrl.wd)
      WD_VAL:   wdata = item_r.value;
      WD_NVAL:  wdata = item_r.new_value;
      WD_RDATA: wdata = rdata_r;
      default:  wdata = rdata_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.we)
      WE_ALWAYS:  mem_we = step_en;
      WE_NOMATCH: mem_we = step_en & ~match;
      default:    mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  always_comb begin
    i_nxt = i_r;
    if (step_en) begin
      unique case (ctrl.iop)
        I_HOLD:        i_nxt = i_r;
        I_ZERO:        i_nxt = '0;
        I_CNT:         i_nxt = cnt_r;
        I_IDX:         i_nxt = idx_ext;
        I_INC:         i_nxt = i_p1;
        I_DEC:         i_nxt = i_m1;
        I_INC_NOMATCH: i_nxt = match ? i_r : i_p1;
        default:       i_nxt = i_r;
      endcase
    end
  end

  always_comb begin
    w_nxt = w_r;
    if (step_en) begin
      unique case (ctrl.wop)
        W_HOLD:        w_nxt = w_r;
        W_ZERO:        w_nxt = '0;
        W_INC_NOMATCH: w_nxt = match ? w_r : w_r + CNT_W'(1);
        default:       w_nxt = w_r;
      endcase
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (step_en) begin
      unique case (ctrl.nop)
        N_HOLD:   cnt_nxt = cnt_r;
        N_INC:    cnt_nxt = cnt_r + CNT_W'(1);
        N_DEC:    cnt_nxt = cnt_r - CNT_W'(1);
        N_LOAD_W: cnt_nxt = w_r;
        default:  cnt_nxt = cnt_r;
      endcase
    end
  end

  // Result fields start at zero for every item and are filled by the step
  // that decides the outcome.
  always_comb begin
    ok_nxt  = ok_r;
    rd_nxt  = rd_r;
    pos_nxt = pos_r;
    if (accept) begin
      ok_nxt  = 1'b0;
      rd_nxt  = '0;
      pos_nxt = '0;
    end else if (step_en) begin
      unique case (ctrl.res)
        R_NONE: ok_nxt = ok_r;
        R_OK:   ok_nxt = 1'b1;
        R_READ: begin
          ok_nxt = 1'b1;
          rd_nxt = rdata_r;
        end
        R_POS: begin
          ok_nxt  = 1'b1;
          pos_nxt = i_r[ADDR_W-1:0];
        end
        R_ALL:   ok_nxt = (w_r != cnt_r);
        default: ok_nxt = ok_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    i_r   <= i_nxt;
    w_r   <= w_nxt;
    ok_r  <= ok_nxt;
    rd_r  <= rd_nxt;
    pos_r <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= done;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item.ok         = ok_r;
  assign out_item.read_value = rd_r;
  assign out_item.position   = pos_r;
  assign out_item.count      = cnt_r;

`ifndef SYNTHESIS
  // The count moves only while an item is being worked on.
  a_cnt_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(cnt_r))
    else $error("count changed while no item was in progress");

  // Compaction never writes ahead of the entry being read.
  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && ctrl.wop == W_INC_NOMATCH) |-> (w_r <= i_r))
    else $error("compaction write pointer passed read pointer");

  // The scan pointer never passes the count of held entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && ctrl.cond == C_SCAN_DONE) |-> (i_r <= cnt_r))
    else $error("scan pointer beyond count");

  // Busy drops between items, so result strobes
  // never abut.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");
`endif

endmodule

// ===== sim/tb_bounded_array_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine_unit: self-checking bench for the list engine
// A clocked driver feeds list operations from a queue of pending items and
// keeps a shadow copy of the list to predict each reply. A clocked monitor
// checks every reply strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import blae_pkg::*;

  // The longest legal quiet stretch is a sender gap plus one full list
  // walk, so this leaves a wide margin before calling it a hang.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_OPS  = 750;

  // One pending operation. When hold_for_drain is set, the driver does not
  // present it until every reply already owed has come back.
  typedef struct {
    blae_in_t item;
    bit       hold_for_drain;
  } list_req_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  blae_in_t  in_item = '0;
  logic      out_valid;
  blae_out_t out_item;

  list_req_t   req_queue[$];
  blae_out_t   replies_due[$];
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_cycles = 0;

  // Shadow list used for prediction. Only slots below list_len are ever read.
  logic signed [DATA_W-1:0] list_mem [CAPACITY];
  int                       list_len = 0;

  bounded_array_list_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #4 clk = ~clk;

  // Closes the hole at pos by pulling every later entry down one slot.
  function automatic void drop_entry(int pos);
    for (int i = pos; i < list_len - 1; i++) begin
      list_mem[i] = list_mem[i + 1];
    end
    list_len--;
  endfunction

  // Applies one operation to the shadow list and returns the reply the
  // engine owes for it.
  function automatic blae_out_t apply_list_op(blae_in_t op);
    blae_out_t r;
    int        hit;
    int        kept;
    r = '0;
    // First position holding the match value, or -1 when there is none.
    hit = -1;
    for (int i = list_len - 1; i >= 0; i--) begin
      if (list_mem[i] == op.value) hit = i;
    end
    case (op.kind)
      KIND_APPEND: begin
        if (list_len < CAPACITY) begin
          list_mem[list_len] = op.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      KIND_INSERT: begin
        // Insert only goes in front of an existing entry, never at the tail.
        if (list_len < CAPACITY && op.index < list_len) begin
          for (int i = list_len; i > op.index; i--) begin
            list_mem[i] = list_mem[i - 1];
          end
          list_mem[op.index] = op.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_AT: begin
        if (op.index < list_len) begin
          drop_entry(op.index);
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_FIRST: begin
        if (hit >= 0) begin
          drop_entry(hit);
          r.ok = 1'b1;
        end
      end
      KIND_REMOVE_ALL: begin
        // Single compacting pass; success means at least one entry went away.
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] != op.value) begin
            list_mem[kept] = list_mem[i];
            kept++;
          end
        end
        r.ok = (kept != list_len);
        list_len = kept;
      end
      KIND_WRITE_AT: begin
        if (op.index < list_len) begin
          list_mem[op.index] = op.value;
          r.ok = 1'b1;
        end
      end
      KIND_WRITE_MATCH: begin
        if (hit >= 0) begin
          list_mem[hit] = op.new_value;
          r.ok = 1'b1;
        end
      end
      KIND_READ_AT: begin
        if (op.index < list_len) begin
          r.read_value = list_mem[op.index];
          r.ok = 1'b1;
        end
      end
      KIND_FIND: begin
        if (hit >= 0) begin
          r.position = ADDR_W'(hit);
          r.ok = 1'b1;
        end
      end
      default: begin
        // Unused codes do nothing; only the count is reported.
      end
    endcase
    r.count = CNT_W'(list_len);
    return r;
  endfunction

  // Driver. An item is taken at an edge where start is high and busy is low.
  // After a take the driver may go quiet for a random burst; a pending item
  // marked for draining waits until no reply is outstanding. Once start is
  // up it stays up with the same item until the engine takes it.
  always @(posedge clk) begin : driver
    bit          took;
    bit          want_gap;
    int unsigned in_flight;
    blae_in_t    noise;
    took = start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else begin
      if (took) begin
        replies_due.push_back(apply_list_op(in_item));
        items_accepted <= items_accepted + 1;
      end
      // Replies arriving on this same edge are counted on the next one, which
      // can only make a drain wait longer, never end it early.
      in_flight = items_accepted + took - results_seen;
      // Gaps stop once the tail of the run is reached, so the end runs flat out.
      want_gap = took && req_queue.size() > 80 && $urandom_range(0, 3) == 0;
      noise.kind = KIND_W'($urandom);
      noise.index = ADDR_W'($urandom);
      noise.value = DATA_W'($urandom);
      noise.new_value = DATA_W'($urandom);
      if (!start || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
          in_item <= noise;
        end else if (want_gap) begin
          gap_left <= $urandom_range(0, 15);
          start <= 1'b0;
          in_item <= noise;
        end else if (req_queue.size() == 0 ||
                     (req_queue[0].hold_for_drain && in_flight != 0)) begin
          start <= 1'b0;
        end else begin
          in_item <= req_queue[0].item;
          start <= 1'b1;
          req_queue.pop_front();
        end
      end
    end
  end

  // Monitor. Each strobe is one reply, compared with the oldest prediction.
  always @(posedge clk) begin : monitor
    blae_out_t want;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (replies_due.size() == 0) begin
        $error("reply strobe with no operation outstanding");
        error_count++;
      end else begin
        want = replies_due.pop_front();
        if (out_item.ok !== want.ok) begin
          $error("ok: expected %0b, actual %0b", want.ok, out_item.ok);
          error_count++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected 0x%08h, actual 0x%08h",
                 want.read_value, out_item.read_value);
          error_count++;
        end
        if (out_item.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_item.position);
          error_count++;
        end
        if (out_item.count !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, out_item.count);
          error_count++;
        end
      end
    end
  end

  // Watchdog. Any take or reply resets the count of quiet cycles.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] idx,
                          logic [DATA_W-1:0] v, logic [DATA_W-1:0] nv, bit drain);
    list_req_t req;
    req.item.kind = kind;
    req.item.index = idx;
    req.item.value = v;
    req.item.new_value = nv;
    req.hold_for_drain = drain;
    req_queue.push_back(req);
  endtask

  // Most values come from a small pool so that matches and duplicates are
  // common; the rest are fully random to toggle every bit.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] pool [6];
    pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0005, 32'h0000_0011};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  initial begin : stimulus
    int                r;
    bit                growing;
    logic [KIND_W-1:0] k;

    // Directed part. Every operation on an empty list is refused, including
    // an insert at position zero, since that would be the tail.
    queue_op(KIND_READ_AT, 0, 0, 0, 0);
    queue_op(KIND_FIND, 0, 0, 0, 0);
    queue_op(KIND_REMOVE_AT, 0, 0, 0, 0);
    queue_op(KIND_REMOVE_FIRST, 0, 0, 0, 0);
    queue_op(KIND_REMOVE_ALL, 0, 0, 0, 0);
    queue_op(KIND_WRITE_MATCH, 0, 0, 32'h1, 0);
    queue_op(KIND_INSERT, 0, 32'h9, 0, 0);
    // Extreme values, with a duplicate of the largest one.
    queue_op(KIND_APPEND, 0, 32'h8000_0000, 0, 0);
    queue_op(KIND_APPEND, 0, 32'h7FFF_FFFF, 0, 0);
    queue_op(KIND_APPEND, 0, 32'hFFFF_FFFF, 0, 0);
    queue_op(KIND_APPEND, 0, 32'h7FFF_FFFF, 0, 0);
    // Insert aimed at the tail position is refused.
    queue_op(KIND_INSERT, 4, 32'h9, 0, 0);
    queue_op(KIND_INSERT, 0, 32'h0, 0, 0);
    // Find and overwrite-by-value both act on the first duplicate only.
    queue_op(KIND_FIND, 0, 32'h7FFF_FFFF, 0, 0);
    queue_op(KIND_WRITE_MATCH, 0, 32'h7FFF_FFFF, 32'h5A5A_A5A5, 0);
    queue_op(KIND_READ_AT, 4, 0, 0, 0);
    queue_op(KIND_WRITE_AT, 1, 32'hFFFF_FFFF, 0, 0);
    // Fill to capacity, then append and insert are both refused.
    queue_op(KIND_APPEND, 7, 32'h1, 0, 0);
    queue_op(KIND_APPEND, 0, 32'h2, 0, 0);
    queue_op(KIND_APPEND, 0, 32'h3, 0, 0);
    queue_op(KIND_APPEND, 0, 32'h4, 0, 0);
    queue_op(KIND_INSERT, 3, 32'h4, 0, 0);
    // Remove the last slot, purge all copies of a value, then out of range.
    queue_op(KIND_REMOVE_AT, 7, 0, 0, 0);
    queue_op(KIND_REMOVE_ALL, 0, 32'hFFFF_FFFF, 0, 0);
    queue_op(KIND_READ_AT, 6, 0, 0, 0);
    // Unused codes leave the list alone.
    queue_op(KIND_W'(KIND_FIND + 1), 0, 0, 0, 0);
    queue_op({KIND_W{1'b1}}, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);

    // Random part. Each phase is picked at random to grow or shrink the list so
    // that it spends time both full and empty. Now and then an item waits for
    // all outstanding replies before it goes out.
    growing = 1'b1;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) growing = ($urandom_range(0, 1) == 1);
      r = $urandom_range(0, 99);
      if (r >= 97) begin
        k = KIND_W'($urandom_range(KIND_FIND + 1, {KIND_W{1'b1}}));
      end else if (growing && r < 35) begin
        k = KIND_APPEND;
      end else if (growing && r < 50) begin
        k = KIND_INSERT;
      end else if (!growing && r < 20) begin
        k = KIND_REMOVE_AT;
      end else if (!growing && r < 32) begin
        k = KIND_REMOVE_FIRST;
      end else if (!growing && r < 38) begin
        k = KIND_REMOVE_ALL;
      end else begin
        k = KIND_W'($urandom_range(KIND_APPEND, KIND_FIND));
      end
      queue_op(k, ADDR_W'($urandom_range(0, CAPACITY - 1)), pick_value(), pick_value(),
               n % 150 == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || start) @(posedge clk);
    while (results_seen != items_accepted) @(posedge clk);
    // Allow one full list walk for any stray reply to show up.
    repeat (2 * CAPACITY + 10) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d predicted replies never arrived", replies_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
